// ===== rtl/core/bfsk_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsk_pkg: shared types and constants
// Status and action codes, the result item layout and default sizes for the
// binary FSK tone sequencer.
// ----------------------------------------------------------------------------
package bfsk_pkg;

  localparam int unsigned NUM_SYMBOLS = 8;
  localparam int unsigned TONE_W = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W = 4;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_REJECTED = 3'd1,
    ST_IDLE     = 3'd2,
    ST_HOLDING  = 3'd3,
    ST_NEXT     = 3'd4,
    ST_FINISHED = 3'd5,
    ST_STOPPED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    REG_ZERO_TONE = 2'd0,
    REG_ONE_TONE  = 2'd1,
    REG_SYM_TICKS = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [TONE_W-1:0] zero_tone;
    logic [TONE_W-1:0] one_tone;
    logic [TICK_W-1:0] symbol_ticks;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic              tone_valid;
    logic [TONE_W-1:0] tone_value;
    logic              busy_res;
  } result_t;

endpackage

// ===== rtl/core/bfsk_core.sv =====
// ----------------------------------------------------------------------------
// bfsk_core: symbol sequencer
// Holds the byte, bit position and hold counter and turns each accepted item
// into its result item in the same cycle.
// ----------------------------------------------------------------------------
module bfsk_core #(
  parameter int unsigned NumSymbols = bfsk_pkg::NUM_SYMBOLS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [1:0]                       action_i,
  input  logic [bfsk_pkg::BYTE_W-1:0]      data_byte_i,
  input  bfsk_pkg::cfg_t                   cfg_i,
  output bfsk_pkg::result_t                result_o
);

  localparam logic [bfsk_pkg::POS_W-1:0] LastPos = bfsk_pkg::POS_W'(NumSymbols - 1);
  localparam logic [bfsk_pkg::POS_W:0]   EndPos  = (bfsk_pkg::POS_W + 1)'(NumSymbols);

  logic                           sending_q, sending_d;
  logic [bfsk_pkg::BYTE_W-1:0]    bits_q, bits_d;
  logic [bfsk_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [bfsk_pkg::TICK_W-1:0]    hold_q, hold_d;

  logic [bfsk_pkg::TICK_W-1:0]    hold_inc;
  logic [bfsk_pkg::POS_W:0]       pos_inc;
  bfsk_pkg::result_t              res;

  function automatic logic [bfsk_pkg::TONE_W-1:0] tone_for(
    input logic [bfsk_pkg::BYTE_W-1:0] bits,
    input logic [bfsk_pkg::POS_W-1:0]  pos,
    input bfsk_pkg::cfg_t              cfg
  );
    logic [bfsk_pkg::POS_W-1:0] sel;
    sel = LastPos - pos;
    if (!sel[bfsk_pkg::POS_W-1] && bits[sel[2:0]]) begin
      return cfg.one_tone;
    end
    return cfg.zero_tone;
  endfunction

  assign hold_inc = hold_q + 1'b1;
  assign pos_inc  = {1'b0, pos_q} + 1'b1;

  always_comb begin
    sending_d      = sending_q;
    bits_d         = bits_q;
    pos_d          = pos_q;
    hold_d         = hold_q;
    res.status     = bfsk_pkg::ST_IDLE;
    res.tone_valid = 1'b0;
    res.tone_value = '0;
    case (bfsk_pkg::action_e'(action_i))
      bfsk_pkg::ACT_START: begin
        if (sending_q) begin
          res.status = bfsk_pkg::ST_REJECTED;
        end else begin
          bits_d         = data_byte_i;
          pos_d          = '0;
          hold_d         = '0;
          sending_d      = 1'b1;
          res.status     = bfsk_pkg::ST_STARTED;
          res.tone_valid = 1'b1;
          res.tone_value = tone_for(data_byte_i, '0, cfg_i);
        end
      end
      bfsk_pkg::ACT_TICK: begin
        if (sending_q) begin
          hold_d = hold_inc;
          if (hold_inc < cfg_i.symbol_ticks) begin
            res.status = bfsk_pkg::ST_HOLDING;
          end else if (pos_inc >= EndPos) begin
            pos_d          = pos_inc[bfsk_pkg::POS_W-1:0];
            sending_d      = 1'b0;
            res.status     = bfsk_pkg::ST_FINISHED;
            res.tone_valid = 1'b1;
          end else begin
            pos_d          = pos_inc[bfsk_pkg::POS_W-1:0];
            hold_d         = '0;
            res.status     = bfsk_pkg::ST_NEXT;
            res.tone_valid = 1'b1;
            res.tone_value = tone_for(bits_q, pos_inc[bfsk_pkg::POS_W-1:0], cfg_i);
          end
        end
      end
      bfsk_pkg::ACT_STOP: begin
        if (sending_q) begin
          sending_d      = 1'b0;
          res.status     = bfsk_pkg::ST_STOPPED;
          res.tone_valid = 1'b1;
        end
      end
      default: begin
        res.status = sending_q ? bfsk_pkg::ST_HOLDING : bfsk_pkg::ST_IDLE;
      end
    endcase
    res.busy_res = sending_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      bits_q    <= '0;
      pos_q     <= '0;
      hold_q    <= '0;
    end else if (step_i) begin
      sending_q <= sending_d;
      bits_q    <= bits_d;
      pos_q     <= pos_d;
      hold_q    <= hold_d;
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q |-> ({1'b0, pos_q} < EndPos))
    else $error("bit position past the last symbol while sending");

  a_finish_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res.status == bfsk_pkg::ST_FINISHED || res.status == bfsk_pkg::ST_STOPPED))
    |=> !sending_q)
    else $error("sequencer still busy after finishing or stopping");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.status == bfsk_pkg::ST_STARTED) |=> (sending_q && pos_q == '0))
    else $error("start did not load the first symbol");

endmodule

// ===== rtl/core/bfsk_obuf.sv =====
// ----------------------------------------------------------------------------
// bfsk_obuf: result buffer
// Two-entry result queue, so that a new item is taken while a finished
// result still waits on a stalled output.
// ----------------------------------------------------------------------------
module bfsk_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bfsk_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output bfsk_pkg::result_t data_o
);

  bfsk_pkg::result_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("item pushed into a full result queue");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd0) || (cnt_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result queue pointers disagree with count");

endmodule

// ===== rtl/core/byte_fsk_tone_modulator.sv =====
// ----------------------------------------------------------------------------
// byte_fsk_tone_modulator: binary FSK tone sequencer
// Sends a byte MSB first as low or high tones, one symbol per bit, advanced
// by tick items and ended by the last symbol or a stop item.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   action_i, data_byte_i
//   out      output     out_valid_o / out_stall_i status_o, tone_valid_o,
//                                                 tone_value_o, busy_res_o
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// State and result are updated in the cycle an item is accepted; the result is
// registered in the result queue and shows after any older one. One item per
// cycle is sustained while the output is not stalled; the two-entry queue sets
// the limit. in_stall_o rises only while two results wait on a stalled output.
// Reset clears the sequencer to idle and all configuration registers to zero.
// ----------------------------------------------------------------------------
module byte_fsk_tone_modulator #(
  parameter int unsigned NumSymbols = bfsk_pkg::NUM_SYMBOLS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [bfsk_pkg::BYTE_W-1:0] data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic                        tone_valid_o,
  output logic [bfsk_pkg::TONE_W-1:0] tone_value_o,
  output logic                        busy_res_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [bfsk_pkg::TONE_W-1:0] cfg_data_i
);

  bfsk_pkg::cfg_t    cfg_q;
  bfsk_pkg::result_t step_res;
  bfsk_pkg::result_t out_res;
  logic              step;
  logic              full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (bfsk_pkg::reg_index_e'(cfg_index_i))
        bfsk_pkg::REG_ZERO_TONE: cfg_q.zero_tone    <= cfg_data_i;
        bfsk_pkg::REG_ONE_TONE:  cfg_q.one_tone     <= cfg_data_i;
        bfsk_pkg::REG_SYM_TICKS: cfg_q.symbol_ticks <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  bfsk_core #(
    .NumSymbols(NumSymbols)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .action_i   (action_i),
    .data_byte_i(data_byte_i),
    .cfg_i      (cfg_q),
    .result_o   (step_res)
  );

  bfsk_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .data_i (step_res),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_res)
  );

  assign status_o     = out_res.status;
  assign tone_valid_o = out_res.tone_valid;
  assign tone_value_o = out_res.tone_value;
  assign busy_res_o   = out_res.busy_res;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for byte_fsk_tone_modulator
// A directed table covers the reset state, every action and the register
// extremes. Random phases follow, mostly whole bytes with some noise, under
// several register settings. The sender and the receiver idle at random.
// Each result is checked against the testbench tone sequencer or its fixed row.
// ----------------------------------------------------------------------------
module tb;
  import bfsk_pkg::*;

  localparam int unsigned MaxGap = 19;
  localparam int unsigned LongHold = 150;
  localparam int unsigned PhaseItems = 240;
  localparam int unsigned SlowPhaseItems = 150;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        code;
    logic [TONE_W-1:0] value;
    logic              fixed;
    result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] action = ACT_NONE;
  logic [BYTE_W-1:0] data_byte = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_ZERO_TONE;
  logic [TONE_W-1:0] cfg_data = '0;
  logic row_fixed = 1'b0;
  result_t row_want = '0;

  logic in_stall_o;
  logic out_valid_o;
  logic [2:0] status_o;
  logic tone_valid_o;
  logic [TONE_W-1:0] tone_value_o;
  logic busy_res_o;

  logic [TONE_W-1:0] cfg_low = '0;
  logic [TONE_W-1:0] cfg_high = '0;
  logic [TICK_W-1:0] cfg_ticks = '0;
  logic tx_active = 1'b0;
  logic [BYTE_W-1:0] tx_byte = '0;
  logic [POS_W-1:0] tx_pos = '0;
  logic [TICK_W-1:0] tx_hold = '0;
  logic [TONE_W-1:0] tx_tone = '0;

  result_t expected_q[$];
  stim_row_t plan[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  logic rx_hold_req = 1'b0;

  byte_fsk_tone_modulator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .action_i    (action),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .tone_valid_o(tone_valid_o),
    .tone_value_o(tone_value_o),
    .busy_res_o  (busy_res_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [TONE_W-1:0] load_symbol();
    int unsigned bit_idx;
    logic sym_bit;
    bit_idx = NUM_SYMBOLS - 1 - tx_pos;
    sym_bit = 1'b0;
    if (bit_idx < BYTE_W) begin
      sym_bit = tx_byte[bit_idx];
    end
    tx_hold = '0;
    tx_tone = sym_bit ? cfg_high : cfg_low;
    return tx_tone;
  endfunction

  function automatic result_t tone_step(input logic [1:0] act, input logic [BYTE_W-1:0] dat);
    result_t r;
    int unsigned nxt;
    r = '{status: ST_IDLE, tone_valid: 1'b0, tone_value: '0, busy_res: 1'b0};
    case (act)
      ACT_START: begin
        if (tx_active) begin
          r.status = ST_REJECTED;
        end else begin
          tx_byte = dat;
          tx_pos = '0;
          tx_active = 1'b1;
          r.tone_value = load_symbol();
          r.tone_valid = 1'b1;
          r.status = ST_STARTED;
        end
      end
      ACT_TICK: begin
        if (tx_active) begin
          tx_hold = tx_hold + 1'b1;
          if (tx_hold < cfg_ticks) begin
            r.status = ST_HOLDING;
          end else begin
            nxt = tx_pos + 1;
            tx_pos = nxt[POS_W-1:0];
            r.tone_valid = 1'b1;
            if (nxt >= NUM_SYMBOLS) begin
              tx_active = 1'b0;
              r.status = ST_FINISHED;
            end else begin
              r.tone_value = load_symbol();
              r.status = ST_NEXT;
            end
          end
        end
      end
      ACT_STOP: begin
        if (tx_active) begin
          tx_active = 1'b0;
          r.tone_valid = 1'b1;
          r.status = ST_STOPPED;
        end
      end
      default: begin
        if (tx_active) begin
          r.status = ST_HOLDING;
        end
      end
    endcase
    r.busy_res = tx_active;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [TONE_W-1:0] want_v,
                              input logic [TONE_W-1:0] got_v);
    mismatch_count++;
    $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t predicted;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $error("result with no item pending: status %0h", status_o);
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status) report_field("status", want.status, status_o);
        if (tone_valid_o !== want.tone_valid) begin
          report_field("tone_valid", want.tone_valid, tone_valid_o);
        end
        if (tone_value_o !== want.tone_value) begin
          report_field("tone_value", want.tone_value, tone_value_o);
        end
        if (busy_res_o !== want.busy_res) report_field("busy_res", want.busy_res, busy_res_o);
      end
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_ZERO_TONE: cfg_low = cfg_data;
        REG_ONE_TONE: cfg_high = cfg_data;
        REG_SYM_TICKS: cfg_ticks = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && in_valid && !in_stall_o) begin
      predicted = tone_step(action, data_byte);
      expected_q.push_back(row_fixed ? row_want : predicted);
    end
  end

  initial begin
    int unsigned gap;
    logic taken;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) rx_quiet = ~rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        taken = out_valid_o;
        @(posedge clk);
      end while (!taken);
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [BYTE_W-1:0] dat,
                           input logic fixed, input result_t want);
    int unsigned gap;
    logic taken;
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= dat;
    row_fixed <= fixed;
    row_want <= want;
    do begin
      @(negedge clk);
      taken = !in_stall_o;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic send_plain(input logic [1:0] act, input logic [BYTE_W-1:0] dat);
    send_item(act, dat, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TONE_W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_tones(input logic [TONE_W-1:0] low, input logic [TONE_W-1:0] high,
                           input logic [TICK_W-1:0] ticks, input logic spare);
    write_reg(REG_ZERO_TONE, low);
    write_reg(REG_ONE_TONE, high);
    write_reg(REG_SYM_TICKS, ticks);
    if (spare) write_reg(REG_SPARE, 16'($urandom));
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned base;
    int unsigned sym;
    int unsigned t;
    int unsigned per_symbol;
    int unsigned r;
    logic cut;
    logic paused;
    base = items_sent;
    paused = 1'b0;
    per_symbol = (cfg_ticks == 0) ? 1 : cfg_ticks;
    while (items_sent - base < n) begin
      if (!paused && items_sent - base >= n / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 9) < 7) begin
        send_plain(ACT_START, 8'($urandom));
        cut = 1'b0;
        for (sym = 0; sym < NUM_SYMBOLS && !cut && items_sent - base < n; sym++) begin
          for (t = 0; t < per_symbol && !cut && items_sent - base < n; t++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
              send_plain(ACT_STOP, 8'($urandom));
              cut = 1'b1;
            end else begin
              if (r < 6) begin
                send_plain(ACT_START, 8'($urandom));
              end else if (r < 8) begin
                send_plain(ACT_NONE, 8'($urandom));
              end
              send_plain(ACT_TICK, 8'($urandom));
            end
          end
        end
      end else begin
        send_plain(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  function automatic stim_row_t item_row(input logic [1:0] act, input logic [BYTE_W-1:0] dat);
    item_row = '{kind: ROW_ITEM, code: act, value: {8'h00, dat}, fixed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t fixed_row(input logic [1:0] act, input logic [BYTE_W-1:0] dat,
                                          input status_e st, input logic v,
                                          input logic [TONE_W-1:0] tone, input logic busy);
    fixed_row = '{kind: ROW_ITEM, code: act, value: {8'h00, dat}, fixed: 1'b1,
                  want: '{status: st, tone_valid: v, tone_value: tone, busy_res: busy}};
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [TONE_W-1:0] val);
    reg_row = '{kind: ROW_REG, code: idx, value: val, fixed: 1'b0, want: '0};
  endfunction

  initial begin
    int unsigned phase;
    // All registers are still zero after reset, so every tone is zero here.
    plan.push_back(fixed_row(ACT_TICK, 8'h00, ST_IDLE, 1'b0, 16'h0000, 1'b0));
    plan.push_back(fixed_row(ACT_STOP, 8'hFF, ST_IDLE, 1'b0, 16'h0000, 1'b0));
    plan.push_back(fixed_row(ACT_NONE, 8'h00, ST_IDLE, 1'b0, 16'h0000, 1'b0));
    plan.push_back(fixed_row(ACT_START, 8'hFF, ST_STARTED, 1'b1, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_START, 8'h00, ST_REJECTED, 1'b0, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_NONE, 8'hFF, ST_HOLDING, 1'b0, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_TICK, 8'h00, ST_NEXT, 1'b1, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_STOP, 8'h00, ST_STOPPED, 1'b1, 16'h0000, 1'b0));
    plan.push_back(reg_row(REG_ONE_TONE, 16'hFFFF));
    plan.push_back(fixed_row(ACT_START, 8'h80, ST_STARTED, 1'b1, 16'hFFFF, 1'b1));
    repeat (NUM_SYMBOLS - 1) plan.push_back(item_row(ACT_TICK, 8'h00));
    plan.push_back(fixed_row(ACT_TICK, 8'h00, ST_FINISHED, 1'b1, 16'h0000, 1'b0));
    plan.push_back(reg_row(REG_ZERO_TONE, 16'hFFFF));
    plan.push_back(reg_row(REG_ONE_TONE, 16'h0000));
    plan.push_back(reg_row(REG_SYM_TICKS, 16'h0002));
    plan.push_back(fixed_row(ACT_START, 8'h7F, ST_STARTED, 1'b1, 16'hFFFF, 1'b1));
    plan.push_back(fixed_row(ACT_TICK, 8'h00, ST_HOLDING, 1'b0, 16'h0000, 1'b1));
    plan.push_back(item_row(ACT_TICK, 8'h00));
    plan.push_back(fixed_row(ACT_START, 8'h55, ST_REJECTED, 1'b0, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_NONE, 8'h00, ST_HOLDING, 1'b0, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_STOP, 8'h00, ST_STOPPED, 1'b1, 16'h0000, 1'b0));
    plan.push_back(reg_row(REG_SYM_TICKS, 16'hFFFF));
    plan.push_back(item_row(ACT_START, 8'h01));
    plan.push_back(fixed_row(ACT_TICK, 8'h00, ST_HOLDING, 1'b0, 16'h0000, 1'b1));
    plan.push_back(fixed_row(ACT_STOP, 8'h00, ST_STOPPED, 1'b1, 16'h0000, 1'b0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        write_reg(plan[i].code, plan[i].value);
      end else begin
        send_item(plan[i].code, plan[i].value[BYTE_W-1:0], plan[i].fixed, plan[i].want);
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          set_tones(16'($urandom), 16'($urandom), 16'h0000, 1'b0);
          // The receiver holds off for a long stretch while items keep coming.
          tx_quiet = 1'b1;
          rx_hold_req = 1'b1;
        end
        1: set_tones(16'h0000, 16'hFFFF, 16'h0001, 1'b0);
        2: set_tones(16'hFFFF, 16'h0000, 16'h0003, 1'b1);
        4: set_tones(16'($urandom), 16'($urandom), 16'hFFFF, 1'b0);
        default: begin
          set_tones(16'($urandom), 16'($urandom), 16'($urandom_range(0, 5)), phase == 6);
        end
      endcase
      run_phase(phase == 4 ? SlowPhaseItems : PhaseItems);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("byte_fsk_tone_modulator test passed");
    end else begin
      $display("byte_fsk_tone_modulator test failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("byte_fsk_tone_modulator test failed");
    $finish;
  end

endmodule
